/* rtl/pell_minimal_solution_assert.svh */
// Assertion macros used by the verification checker of this block.
`ifndef PELL_MINIMAL_SOLUTION_ASSERT_SVH
`define PELL_MINIMAL_SOLUTION_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define PMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that also holds during reset.
`define PMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Shared constants, types and codes of the Pell solution engine.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int unsigned D_BITS     = 32;
  localparam int unsigned VALUE_BITS = 64;

  // Continued fraction terms m, q, a stay below 2*sqrt(d); this is roomy.
  localparam int unsigned CF_W = D_BITS + 2;

  localparam int unsigned ISQ_STEPS = (D_BITS + 1) / 2;
  localparam int unsigned ISQ_CNT_W = $clog2(ISQ_STEPS + 1);

  // Wide multiplier: 128-bit by 64-bit operands, 32-bit limbs, 128-bit result.
  localparam int unsigned PROD_W     = 128;
  localparam int unsigned OPB_W      = 64;
  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned MUL_PAIRS  = 8;
  localparam int unsigned PAIR_CNT_W = 3;

  localparam int unsigned DIV_CNT_W = $clog2(CF_W + 1);

  localparam logic [PROD_W:0] VALUE_MAX_W =
      {{(PROD_W + 1 - VALUE_BITS){1'b0}}, {VALUE_BITS{1'b1}}};

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_SQUARE   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [D_BITS-1:0] d;
    logic [CF_W-1:0]   a0;
    logic              square;
  } job_t;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] a;
    logic [OPB_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic            go;
    logic [CF_W-1:0] num;
    logic [CF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CF_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/pms_in_if.sv */
// ----------------------------------------------------------------------------
// pms_in_if
// Input channel carrying the coefficient d.
// ----------------------------------------------------------------------------
interface pms_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] d_value;

  modport source (output valid, output d_value, input ready);
  modport sink (input valid, input d_value, output ready);
endinterface

/* rtl/pms_out_if.sv */
// ----------------------------------------------------------------------------
// pms_out_if
// Result channel carrying the least solution and its status.
// ----------------------------------------------------------------------------
interface pms_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_solution;
  logic [63:0] y_solution;
  logic [1:0]  status;

  modport source (output valid, output x_solution, output y_solution, output status,
                  input ready);
  modport sink (input valid, input x_solution, input y_solution, input status,
                output ready);
endinterface

/* rtl/pms_front.sv */
// ----------------------------------------------------------------------------
// pms_front
// Accepts d, finds floor(sqrt(d)) two bits a cycle and flags perfect squares.
// ----------------------------------------------------------------------------
module pms_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  pms_in_if.sink           in_i,
  output logic             push_o,
  output pms_pkg::job_t    job_o,
  input  logic             full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_PUSH
  } fstate_e;

  localparam logic [pms_pkg::D_BITS-1:0] ISQ_TOP =
      pms_pkg::D_BITS'(1) << (2 * (pms_pkg::ISQ_STEPS - 1));

  fstate_e                          state_q;
  logic [pms_pkg::D_BITS-1:0]       d_q;
  logic [pms_pkg::D_BITS-1:0]       v_q;
  logic [pms_pkg::D_BITS-1:0]       res_q;
  logic [pms_pkg::D_BITS-1:0]       bit_q;
  logic [pms_pkg::ISQ_CNT_W-1:0]    cnt_q;
  logic [pms_pkg::D_BITS:0]         trial;

  assign in_i.ready = (state_q == F_IDLE);
  assign trial      = {1'b0, res_q} + {1'b0, bit_q};
  assign push_o     = (state_q == F_PUSH) && !full_i;

  assign job_o.d      = d_q;
  assign job_o.a0     = pms_pkg::CF_W'(res_q);
  assign job_o.square = (v_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            d_q     <= in_i.d_value[pms_pkg::D_BITS-1:0];
            v_q     <= in_i.d_value[pms_pkg::D_BITS-1:0];
            res_q   <= '0;
            bit_q   <= ISQ_TOP;
            cnt_q   <= '0;
            state_q <= F_RUN;
          end
        end
        F_RUN: begin
          if ({1'b0, v_q} >= trial) begin
            v_q   <= v_q - trial[pms_pkg::D_BITS-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == pms_pkg::ISQ_CNT_W'(pms_pkg::ISQ_STEPS - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pms_fifo.sv */
// ----------------------------------------------------------------------------
// pms_fifo
// Two-entry queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module pms_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pms_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pms_pkg::job_t job_o
);

  pms_pkg::job_t mem_q [2];
  logic          wr_q;
  logic          rd_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/pms_mul.sv */
// ----------------------------------------------------------------------------
// pms_mul
// Wide multiplier built from one 32x32 multiplier, one limb pair a cycle.
// ----------------------------------------------------------------------------
module pms_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pms_pkg::mul_req_t req_i,
  output pms_pkg::mul_rsp_t rsp_o
);

  logic [pms_pkg::PROD_W-1:0]     a_q;
  logic [pms_pkg::OPB_W-1:0]      b_q;
  logic [pms_pkg::PROD_W-1:0]     acc_q;
  logic [2*pms_pkg::LIMB_W-1:0]   pp_q;
  logic [2:0]                     sh_q;
  logic [pms_pkg::PAIR_CNT_W:0]   cnt_q;
  logic                           busy_q;
  logic                           pv_q;
  logic                           last_q;
  logic                           done_q;
  logic [pms_pkg::LIMB_W-1:0]     a_limb;
  logic [pms_pkg::LIMB_W-1:0]     b_limb;
  logic [pms_pkg::PROD_W-1:0]     pp_ext;

  assign a_limb = a_q[cnt_q[1:0]*pms_pkg::LIMB_W +: pms_pkg::LIMB_W];
  assign b_limb = b_q[cnt_q[2]*pms_pkg::LIMB_W +: pms_pkg::LIMB_W];
  // Partial products at or above bit 128 fall off, as in a 128-bit wrap.
  assign pp_ext = {{(pms_pkg::PROD_W - 2*pms_pkg::LIMB_W){1'b0}}, pp_q} << {sh_q, 5'b0};

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= pv_q && last_q;
      if (req_i.go) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        last_q <= 1'b0;
      end else if (busy_q) begin
        if (cnt_q != (pms_pkg::PAIR_CNT_W+1)'(pms_pkg::MUL_PAIRS)) begin
          pp_q   <= a_limb * b_limb;
          sh_q   <= {1'b0, cnt_q[1:0]} + {2'b0, cnt_q[2]};
          pv_q   <= 1'b1;
          last_q <= (cnt_q == (pms_pkg::PAIR_CNT_W+1)'(pms_pkg::MUL_PAIRS - 1));
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          pv_q   <= 1'b0;
          busy_q <= 1'b0;
        end
        if (pv_q) begin
          acc_q <= acc_q + pp_ext;
        end
      end
    end
  end

endmodule

/* rtl/pms_div.sv */
// ----------------------------------------------------------------------------
// pms_div
// Restoring divider for the continued fraction terms, one bit a cycle.
// ----------------------------------------------------------------------------
module pms_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pms_pkg::div_req_t req_i,
  output pms_pkg::div_rsp_t rsp_o
);

  logic [pms_pkg::CF_W-1:0]      den_q;
  logic [pms_pkg::CF_W-1:0]      quo_q;
  logic [pms_pkg::CF_W:0]        rem_q;
  logic [pms_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [pms_pkg::CF_W:0]        trial;

  assign trial      = {rem_q[pms_pkg::CF_W-1:0], quo_q[pms_pkg::CF_W-1]};
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        den_q  <= req_i.den;
        quo_q  <= req_i.num;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          quo_q <= {quo_q[pms_pkg::CF_W-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[pms_pkg::CF_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pms_pkg::DIV_CNT_W'(pms_pkg::CF_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/pms_back.sv */
// ----------------------------------------------------------------------------
// pms_back
// Continued fraction sequencer: convergents, exact Pell test, overflow check.
// ----------------------------------------------------------------------------
module pms_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pms_pkg::job_t job_i,
  output logic          pop_o,
  pms_out_if.source     out_o
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_TEST_HH,
    B_TEST_KK,
    B_TEST_DKK,
    B_CF_AQ,
    B_CF_M,
    B_CF_MM,
    B_DIV_Q,
    B_DIV_A,
    B_MUL_AH,
    B_MUL_AK,
    B_DONE
  } bstate_e;

  localparam int unsigned VB = pms_pkg::VALUE_BITS;
  localparam int unsigned CW = pms_pkg::CF_W;

  bstate_e                     state_q;
  logic [pms_pkg::D_BITS-1:0]  d_q;
  logic [CW-1:0]               a0_q;
  logic [CW-1:0]               m_q;
  logic [CW-1:0]               q_q;
  logic [CW-1:0]               a_q;
  logic [CW-1:0]               t_q;
  logic [VB-1:0]               h_q;
  logic [VB-1:0]               hp_q;
  logic [VB-1:0]               k_q;
  logic [VB-1:0]               kp_q;
  logic [VB-1:0]               nh_q;
  logic [pms_pkg::PROD_W-1:0]  hh_q;
  logic                        valid_q;
  logic [63:0]                 x_q;
  logic [63:0]                 y_q;
  pms_pkg::status_e            status_q;
  pms_pkg::mul_req_t           mreq_q;
  pms_pkg::mul_rsp_t           mrsp;
  pms_pkg::div_req_t           dreq_q;
  pms_pkg::div_rsp_t           drsp;
  logic [2*CW-1:0]             aq_full;
  logic [2*CW-1:0]             mm_full;
  logic [CW-1:0]               quo_nz;
  logic [pms_pkg::PROD_W:0]    sum_h;
  logic [pms_pkg::PROD_W-1:0]  sum_k;

  pms_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  pms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq_q),
    .rsp_o  (drsp)
  );

  assign pop_o   = (state_q == B_IDLE) && valid_i;
  assign aq_full = a_q * q_q;
  assign mm_full = m_q * m_q;
  // Zero quotients cannot occur for a nonsquare d; they are forced to one.
  assign quo_nz  = (drsp.quo == '0) ? CW'(1) : drsp.quo;
  assign sum_h   = {1'b0, mrsp.prod} + {{(pms_pkg::PROD_W + 1 - VB){1'b0}}, hp_q};
  assign sum_k   = mrsp.prod + {{(pms_pkg::PROD_W - VB){1'b0}}, kp_q};

  assign out_o.valid      = valid_q;
  assign out_o.x_solution = x_q;
  assign out_o.y_solution = y_q;
  assign out_o.status     = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      valid_q   <= 1'b0;
      mreq_q.go <= 1'b0;
      dreq_q.go <= 1'b0;
    end else begin
      mreq_q.go <= 1'b0;
      dreq_q.go <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            d_q  <= job_i.d;
            a0_q <= job_i.a0;
            m_q  <= '0;
            q_q  <= CW'(1);
            a_q  <= job_i.a0;
            h_q  <= VB'(job_i.a0);
            hp_q <= VB'(1);
            k_q  <= VB'(1);
            kp_q <= '0;
            if (job_i.square) begin
              x_q      <= '0;
              y_q      <= '0;
              status_q <= pms_pkg::ST_SQUARE;
              valid_q  <= 1'b1;
              state_q  <= B_DONE;
            end else begin
              mreq_q.go <= 1'b1;
              mreq_q.a  <= pms_pkg::PROD_W'(job_i.a0);
              mreq_q.b  <= pms_pkg::OPB_W'(job_i.a0);
              state_q   <= B_TEST_HH;
            end
          end
        end
        B_TEST_HH: begin
          if (mrsp.done) begin
            hh_q      <= mrsp.prod;
            mreq_q.go <= 1'b1;
            mreq_q.a  <= pms_pkg::PROD_W'(k_q);
            mreq_q.b  <= pms_pkg::OPB_W'(k_q);
            state_q   <= B_TEST_KK;
          end
        end
        B_TEST_KK: begin
          if (mrsp.done) begin
            mreq_q.go <= 1'b1;
            mreq_q.a  <= mrsp.prod;
            mreq_q.b  <= pms_pkg::OPB_W'(d_q);
            state_q   <= B_TEST_DKK;
          end
        end
        B_TEST_DKK: begin
          if (mrsp.done) begin
            if (mrsp.prod + 1'b1 == hh_q) begin
              x_q      <= 64'(h_q);
              y_q      <= 64'(k_q);
              status_q <= pms_pkg::ST_FOUND;
              valid_q  <= 1'b1;
              state_q  <= B_DONE;
            end else begin
              state_q <= B_CF_AQ;
            end
          end
        end
        B_CF_AQ: begin
          t_q     <= aq_full[CW-1:0];
          state_q <= B_CF_M;
        end
        B_CF_M: begin
          m_q     <= t_q - m_q;
          state_q <= B_CF_MM;
        end
        B_CF_MM: begin
          dreq_q.go  <= 1'b1;
          dreq_q.num <= CW'(d_q) - mm_full[CW-1:0];
          dreq_q.den <= q_q;
          state_q    <= B_DIV_Q;
        end
        B_DIV_Q: begin
          if (drsp.done) begin
            q_q        <= quo_nz;
            dreq_q.go  <= 1'b1;
            dreq_q.num <= a0_q + m_q;
            dreq_q.den <= quo_nz;
            state_q    <= B_DIV_A;
          end
        end
        B_DIV_A: begin
          if (drsp.done) begin
            a_q       <= quo_nz;
            mreq_q.go <= 1'b1;
            mreq_q.a  <= pms_pkg::PROD_W'(quo_nz);
            mreq_q.b  <= pms_pkg::OPB_W'(h_q);
            state_q   <= B_MUL_AH;
          end
        end
        B_MUL_AH: begin
          if (mrsp.done) begin
            // The next numerator a*h + hp must fit the value width.
            if (sum_h > pms_pkg::VALUE_MAX_W) begin
              x_q      <= '0;
              y_q      <= '0;
              status_q <= pms_pkg::ST_OVERFLOW;
              valid_q  <= 1'b1;
              state_q  <= B_DONE;
            end else begin
              nh_q      <= sum_h[VB-1:0];
              mreq_q.go <= 1'b1;
              mreq_q.a  <= pms_pkg::PROD_W'(a_q);
              mreq_q.b  <= pms_pkg::OPB_W'(k_q);
              state_q   <= B_MUL_AK;
            end
          end
        end
        B_MUL_AK: begin
          if (mrsp.done) begin
            kp_q      <= k_q;
            k_q       <= sum_k[VB-1:0];
            hp_q      <= h_q;
            h_q       <= nh_q;
            mreq_q.go <= 1'b1;
            mreq_q.a  <= pms_pkg::PROD_W'(nh_q);
            mreq_q.b  <= pms_pkg::OPB_W'(nh_q);
            state_q   <= B_TEST_HH;
          end
        end
        B_DONE: begin
          if (out_o.ready) begin
            valid_q <= 1'b0;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pell_minimal_solution.sv */
// Operation: a perfect square is reported from the front end's flag; otherwise each
// continued fraction step runs five wide products, two divisions and three update
// states in the back end.
// Throughput: one item at a time in the back end; the square root of the next item
// overlaps through a two-entry job queue.
// Reset: asynchronous, active low; clears all control state, the queue is empty.
// ----------------------------------------------------------------------------
// pell_minimal_solution
// Least solution of x*x - d*y*y = 1 by the continued fraction of sqrt(d).
// ----------------------------------------------------------------------------
module pell_minimal_solution (
  input  logic      clk_i,
  input  logic      rst_ni,
  pms_in_if.sink    in_i,
  pms_out_if.source out_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          job_valid;
  pms_pkg::job_t job_in;
  pms_pkg::job_t job_out;

  pms_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .job_o  (job_in),
    .full_i (full)
  );

  pms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  pms_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/pms_checker.sv */
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks on the result channel of the Pell solution engine.
// ----------------------------------------------------------------------------
`include "pell_minimal_solution_assert.svh"

module pms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] x_i,
  input logic [63:0] y_i,
  input logic [1:0]  status_i
);

  `PMS_ASSERT(a_fail_zero, out_valid_i && (status_i != pms_pkg::ST_FOUND) |-> (x_i == 64'd0) && (y_i == 64'd0), "Failed result carries a nonzero solution")
  `PMS_ASSERT(a_found_order, out_valid_i && (status_i == pms_pkg::ST_FOUND) |-> (x_i > y_i) && (y_i != 64'd0), "Found solution has x not above a nonzero y")
  `PMS_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(x_i) && $stable(status_i), "Stalled result changed")

endmodule

bind pell_minimal_solution pms_checker u_pms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .x_i         (out_o.x_solution),
  .y_i         (out_o.y_solution),
  .status_i    (out_o.status)
);

/* dv/pell_minimal_solution_tb.sv */
// ----------------------------------------------------------------------------
// pell_minimal_solution_tb
// Feeds the coefficient d to the Pell solver and checks every solution.
// A short table covers squares, small known solutions and wide inputs. Random
// coefficients follow, most of them small and a few across the full width.
// Each result is compared field by field with its table entry or a built-in
// solver. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module pell_minimal_solution_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0]      x;
    logic [63:0]      y;
    pms_pkg::status_e st;
  } solution_t;

  typedef struct {
    logic [31:0]      d;
    bit               known;
    logic [63:0]      x;
    logic [63:0]      y;
    pms_pkg::status_e st;
  } vector_t;

  localparam int unsigned RANDOM_ITEMS = 100;

  logic clk;
  logic rst_n;
  int   errors;

  solution_t solutions_pending[$];

  pms_in_if  in_if ();
  pms_out_if out_if ();

  pell_minimal_solution uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL pell_minimal_solution");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Least solution by continued fraction, using exact wide arithmetic.
  function automatic solution_t solve_pell(input logic [31:0] d_in);
    logic [63:0]  d, a0, m, q, a, h, hp, k, kp, nh, nk, rem, bitv, vmax;
    logic [127:0] lhs, rhs;
    solution_t    r;
    d    = 64'(d_in[pms_pkg::D_BITS-1:0]);
    vmax = 64'((128'(1) << pms_pkg::VALUE_BITS) - 1);
    a0   = 0;
    rem  = d;
    bitv = 64'(1) << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= a0 + bitv) begin
        rem = rem - (a0 + bitv);
        a0  = (a0 >> 1) + bitv;
      end else begin
        a0 = a0 >> 1;
      end
      bitv = bitv >> 2;
    end
    r.x  = '0;
    r.y  = '0;
    r.st = pms_pkg::ST_SQUARE;
    if (a0 * a0 == d) return r;
    m  = 0;
    q  = 1;
    a  = a0;
    h  = a0;
    hp = 1;
    k  = 1;
    kp = 0;
    while (1) begin
      lhs = 128'(h) * 128'(h);
      rhs = 128'(d) * 128'(k) * 128'(k) + 128'(1);
      if (lhs == rhs) begin
        r.x  = h;
        r.y  = k;
        r.st = pms_pkg::ST_FOUND;
        return r;
      end
      m = a * q - m;
      q = (d - m * m) / q;
      if (q == 0) q = 1;
      a = (a0 + m) / q;
      if (a == 0) a = 1;
      if (hp > vmax || h > (vmax - hp) / a) begin
        r.st = pms_pkg::ST_OVERFLOW;
        return r;
      end
      nh = a * h + hp;
      nk = a * k + kp;
      hp = h;
      h  = nh;
      kp = k;
      k  = nk;
    end
  endfunction

  // Mostly no idling or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_d();
    int unsigned r;
    logic [31:0] n;
    r = $urandom_range(99);
    if (r < 10) begin
      n = $urandom_range(65535);
      return n * n;
    end
    if (r < 65) return $urandom_range(200);
    if (r < 85) return $urandom_range(5000);
    return $urandom();
  endfunction

  vector_t directed[$] = '{
    '{32'd0,         1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'd1,         1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'd4,         1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'h0001_0000, 1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'h4000_0000, 1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'hFFFE_0001, 1'b1, 64'd0,          64'd0,         pms_pkg::ST_SQUARE},
    '{32'd2,         1'b1, 64'd3,          64'd2,         pms_pkg::ST_FOUND},
    '{32'd3,         1'b1, 64'd2,          64'd1,         pms_pkg::ST_FOUND},
    '{32'd5,         1'b1, 64'd9,          64'd4,         pms_pkg::ST_FOUND},
    '{32'd61,        1'b1, 64'd1766319049, 64'd226153980, pms_pkg::ST_FOUND},
    '{32'd7,         1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'd109,       1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'd991,       1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'hFFFF_FFFF, 1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'hFFFF_FFFE, 1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'h8000_0000, 1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'h5555_5555, 1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND},
    '{32'hAAAA_AAAA, 1'b0, 64'd0,          64'd0,         pms_pkg::ST_FOUND}
  };

  // Drives one coefficient and waits for its transaction.
  task automatic send_d(input vector_t v);
    int unsigned gap;
    solution_t   s;
    gap = pick_gap();
    if (gap > 0 && in_if.valid) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.d_value <= v.d;
    do @(posedge clk); while (!in_if.ready);
    if (v.known) begin
      s.x  = v.x;
      s.y  = v.y;
      s.st = v.st;
    end else begin
      s = solve_pell(v.d);
    end
    solutions_pending.push_back(s);
  endtask

  initial begin
    vector_t v;
    errors        = 0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.d_value = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_d(directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      v.d     = pick_d();
      v.known = 1'b0;
      v.x     = '0;
      v.y     = '0;
      v.st    = pms_pkg::ST_FOUND;
      send_d(v);
    end
    in_if.valid <= 1'b0;
    while (solutions_pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS pell_minimal_solution");
    end else begin
      $display("FAIL pell_minimal_solution");
    end
    $finish;
  end

  // Result side backpressure: stretches of ready, then random stalls.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk);
      out_if.ready <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    solution_t s;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (solutions_pending.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        s = solutions_pending.pop_front();
        if (out_if.x_solution !== s.x)
          report_mismatch($sformatf("x_solution %0d, expected %0d", out_if.x_solution, s.x));
        if (out_if.y_solution !== s.y)
          report_mismatch($sformatf("y_solution %0d, expected %0d", out_if.y_solution, s.y));
        if (out_if.status !== s.st)
          report_mismatch($sformatf("status %0d, expected %0d", out_if.status, s.st));
      end
    end
  end

endmodule

/* pell_minimal_solution.f */
+incdir+rtl
rtl/pms_pkg.sv
rtl/pms_in_if.sv
rtl/pms_out_if.sv
rtl/pms_front.sv
rtl/pms_fifo.sv
rtl/pms_mul.sv
rtl/pms_div.sv
rtl/pms_back.sv
rtl/pell_minimal_solution.sv
rtl/pms_checker.sv
dv/pell_minimal_solution_tb.sv
